// File: hdl/mmcs_pkg.sv
package mmcs_pkg;

  localparam int PIX_W = 8;
  localparam int NUM_W = 2 * PIX_W;
  localparam int CNT_W = $clog2(PIX_W);

  localparam logic [PIX_W-1:0] STRETCH_TOP = 8'd254;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_APPLY   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] den;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hdl/min_max_contrast_stretch.sv
// Min-max contrast stretch for 8-bit grey pixels over a frame sent twice. Measure beats
// (tuser kind 0) update a registered running minimum and maximum; tuser first restarts
// both from that pixel. Apply beats (kind 1) each return floor(254*(p-min)/(max-min)),
// with pixels outside the range clamped to 0 or 254, and stretched 0 with flat set when
// max is not above min (also before any measure). An apply beat goes from accept to the
// output register through a setup state, which forms 254*(p-min) by shift and subtract,
// a restoring divider producing one quotient bit per cycle until 8 bits are formed, and
// a done state. Clamped and flat pixels skip the divider. The input is not ready while
// an apply beat is in work; the output register holds a finished result so the next
// beat can be taken while it waits.
module min_max_contrast_stretch
  import mmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic [1:0] s_axis_tuser,   // [0] kind, [1] first
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] stretched
  output logic       m_axis_tuser    // [0] flat
);

  state_t           state;
  state_t           state_next;
  logic [PIX_W-1:0] run_min;
  logic [PIX_W-1:0] run_max;
  logic [PIX_W-1:0] offs;
  logic [PIX_W-1:0] span;
  logic             bypass;
  logic [PIX_W-1:0] res_val;
  logic             res_flat;
  logic             in_acc;
  logic             out_load;
  logic [PIX_W-1:0] pix;
  logic             kind;
  logic             first;
  logic             is_flat;
  logic             below;
  logic             above;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [PIX_W-1:0] quot;

  assign pix   = s_axis_tdata;
  assign kind  = s_axis_tuser[0];
  assign first = s_axis_tuser[1];

  assign is_flat = run_max <= run_min;
  assign below   = pix < run_min;
  assign above   = pix > run_max;
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  mmcs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .sts  (div_sts),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    div_ctl.start = 1'b0;
    // 254*d as (d << 8) - (d << 1)
    div_ctl.num   = {offs, {PIX_W{1'b0}}} - {{(PIX_W-1){1'b0}}, offs, 1'b0};
    div_ctl.den   = span;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && kind == KIND_APPLY) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (bypass) begin
          state_next = ST_DONE;
        end else begin
          div_ctl.start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= STRETCH_TOP + 1'b1;
      run_max <= '0;
    end else if (in_acc && kind == KIND_MEASURE) begin
      if (first) begin
        run_min <= pix;
        run_max <= pix;
      end else begin
        if (below) run_min <= pix;
        if (above) run_max <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_APPLY) begin
      offs     <= pix - run_min;
      span     <= run_max - run_min;
      bypass   <= is_flat || below || above;
      res_flat <= is_flat;
      res_val  <= (!is_flat && above) ? STRETCH_TOP : '0;
    end else if (state == ST_DIV && div_sts.done) begin
      res_val <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_val;
      m_axis_tuser <= res_flat;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_sts.busy || div_sts.done)
    else $error("divide state with idle divider");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata <= STRETCH_TOP)
    else $error("stretched value above top of range");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("flat result with nonzero value");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("output register overwritten while held");

endmodule

// File: hdl/mmcs_div.sv
module mmcs_div
  import mmcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  output div_sts_t         sts,
  output logic [PIX_W-1:0] quot
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [PIX_W-1:0] rem;
  logic [PIX_W-1:0] lo;
  logic [PIX_W-1:0] den_q;
  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   diff;
  logic             ge;

  // restoring step: bring down one numerator bit, subtract if it fits
  assign trial = {rem, lo[PIX_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PIX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      // quotient fits 8 bits since the high half is below the divisor
      rem   <= ctl.num[NUM_W-1:PIX_W];
      lo    <= ctl.num[PIX_W-1:0];
      den_q <= ctl.den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      lo   <= {lo[PIX_W-2:0], 1'b0};
      quot <= {quot[PIX_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule
